// File: hw/rtl/sshm_pkg.sv
// Shared types and constants for the sensor sample health monitor.
// Holds cause codes, status bit positions, field widths and the sequence-tracking state type.
// No dependencies.
package sshm_pkg;

    localparam int CodesW = 32;
    localparam int ScaleW = 16;
    localparam int ProdW  = CodesW + ScaleW;
    localparam int ValueW = 40;
    localparam int FracW  = 8;
    localparam int CauseW = 3;
    localparam int SeqW   = 8;
    localparam int StatW  = 8;
    localparam int ThrW   = 8;

    localparam logic [CauseW-1:0] CAUSE_OK       = 3'd0;
    localparam logic [CauseW-1:0] CAUSE_PANELOFF = 3'd1;
    localparam logic [CauseW-1:0] CAUSE_ABSENT   = 3'd2;
    localparam logic [CauseW-1:0] CAUSE_NOSYNC   = 3'd3;
    localparam logic [CauseW-1:0] CAUSE_BUSERR   = 3'd4;
    localparam logic [CauseW-1:0] CAUSE_STALE    = 3'd5;
    localparam logic [CauseW-1:0] CAUSE_STUCK    = 3'd6;
    localparam logic [CauseW-1:0] CAUSE_NONE     = 3'd7;

    localparam int ST_VALID      = 0;
    localparam int ST_PANEL_ON   = 2;
    localparam int ST_PRESENT    = 3;
    localparam int ST_CONVERTING = 4;
    localparam int ST_ERROR      = 7;

    localparam logic [0:0] REG_SCALE  = 1'b0;
    localparam logic [0:0] REG_THRESH = 1'b1;

    localparam logic [ScaleW-1:0] SCALE_RESET  = 16'd256;
    localparam logic [ThrW-1:0]   THRESH_RESET = 8'd5;

    typedef struct packed {
        logic            seq_seen;
        logic [SeqW-1:0] prev_seq;
        logic [ThrW-1:0] repeat_count;
    } t_seq_state;

    typedef struct packed {
        logic              ok;
        logic [CauseW-1:0] cause;
        logic [ProdW-1:0]  prod;
    } t_eval_res;

endpackage

// File: hw/rtl/sensor_sample_health_monitor.sv
// Top level of the sensor sample health monitor: stream ports, configuration registers,
// input and result registers. Depends on sshm_pkg and sshm_eval.
//
// Takes one sensor read request per clock and returns one result per request. A request is
// captured in an input register, evaluated combinationally (repeat tracking, cause
// priority, 32x16 scaling multiply) and held in a result register, which presents the
// result until it is taken. The input and result registers each advance once per clock,
// so the block sustains one request per clock when the result side is ready. While a
// result waits, one further request can still enter the input register if that register
// is empty. Write scale_q8_8 (index 0) and stuck_threshold (index 1) only while no
// request is in flight.
module sensor_sample_health_monitor
    import sshm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // bus_ok [0], status_bits [8:1], sample_seq [16:9], sample_codes [48:17], zero [55:49]
    input  logic [55:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // reading_ok [0], scaled_value [40:1], cause [43:41], cause_changed [44], healthy [45],
    // zero [47:46]
    output logic [47:0]   m_axis_tdata
);

    logic [ScaleW-1:0] r_scale;
    logic [ThrW-1:0]   r_thresh;

    logic              r_in_valid;
    logic              r_in_bus_ok;
    logic [StatW-1:0]  r_in_status;
    logic [SeqW-1:0]   r_in_seq;
    logic [CodesW-1:0] r_in_codes;

    t_seq_state        r_state;
    t_seq_state        n_state;
    logic [CauseW-1:0] r_prev_cause;

    logic              r_out_valid;
    logic              r_out_ok;
    logic [ProdW-1:0]  r_out_prod;
    logic [CauseW-1:0] r_out_cause;
    logic              r_out_changed;

    t_eval_res         eval_res;
    logic              out_adv;
    logic              in_fire;
    logic [ValueW-1:0] scaled;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    sshm_eval u_eval (
        .i_bus_ok       (r_in_bus_ok),
        .i_status_bits  (r_in_status),
        .i_sample_seq   (r_in_seq),
        .i_sample_codes (r_in_codes),
        .i_scale        (r_scale),
        .i_thresh       (r_thresh),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_res          (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE:  r_scale  <= i_cfg_data;
                REG_THRESH: r_thresh <= i_cfg_data[ThrW-1:0];
                default:    r_scale  <= r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_bus_ok <= s_axis_tdata[0];
            r_in_status <= s_axis_tdata[8:1];
            r_in_seq    <= s_axis_tdata[16:9];
            r_in_codes  <= s_axis_tdata[48:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_state      <= '0;
            r_prev_cause <= CAUSE_NONE;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state      <= n_state;
                r_prev_cause <= eval_res.cause;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out_ok      <= eval_res.ok;
            r_out_prod    <= eval_res.prod;
            r_out_cause   <= eval_res.cause;
            r_out_changed <= (eval_res.cause != r_prev_cause);
        end
    end

    assign scaled        = r_out_ok ? r_out_prod[ProdW-1:FracW] : '0;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_ok, r_out_changed, r_out_cause, scaled, r_out_ok};

endmodule

// File: hw/rtl/sshm_eval.sv
// Per-request evaluation: sequence repeat tracking, cause classification and product with the Q8.8 scale.
// Purely combinational; depends on sshm_pkg.
module sshm_eval
    import sshm_pkg::*;
(
    input  logic              i_bus_ok,
    input  logic [StatW-1:0]  i_status_bits,
    input  logic [SeqW-1:0]   i_sample_seq,
    input  logic [CodesW-1:0] i_sample_codes,
    input  logic [ScaleW-1:0] i_scale,
    input  logic [ThrW-1:0]   i_thresh,
    input  t_seq_state        i_state,
    output t_seq_state        o_state,
    output t_eval_res         o_res
);

    logic            seq_match;
    logic [ThrW-1:0] cnt_next;
    logic [CauseW-1:0] invalid_cause;

    assign seq_match = i_state.seq_seen && (i_sample_seq == i_state.prev_seq);

    always_comb begin
        if (!seq_match) begin
            cnt_next = '0;
        end else if (i_state.repeat_count < i_thresh) begin
            cnt_next = i_state.repeat_count + ThrW'(1);
        end else begin
            cnt_next = i_state.repeat_count;
        end
    end

    always_comb begin
        if (!i_status_bits[ST_PANEL_ON]) begin
            invalid_cause = CAUSE_PANELOFF;
        end else if (i_status_bits[ST_ERROR]) begin
            invalid_cause = CAUSE_BUSERR;
        end else if (!i_status_bits[ST_PRESENT]) begin
            invalid_cause = CAUSE_ABSENT;
        end else if (!i_status_bits[ST_CONVERTING]) begin
            invalid_cause = CAUSE_NOSYNC;
        end else begin
            invalid_cause = CAUSE_STALE;
        end
    end

    always_comb begin
        o_res.prod = ProdW'(i_sample_codes) * ProdW'(i_scale);
        o_res.ok   = 1'b0;
        if (!i_bus_ok) begin
            o_state     = i_state;
            o_res.cause = CAUSE_BUSERR;
        end else begin
            o_state.seq_seen     = 1'b1;
            o_state.prev_seq     = i_sample_seq;
            o_state.repeat_count = cnt_next;
            if (cnt_next >= i_thresh) begin
                o_res.cause = CAUSE_STUCK;
            end else if (!i_status_bits[ST_VALID]) begin
                o_res.cause = invalid_cause;
            end else begin
                o_res.cause = CAUSE_OK;
                o_res.ok    = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/sshm_check.sv
// Port-level checker for the sensor sample health monitor, bound to the top level.
// Depends on sshm_pkg for cause codes.
module sshm_check
    import sshm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata
);

    logic [CauseW-1:0] r_last_cause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cause <= CAUSE_NONE;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_last_cause <= m_axis_tdata[43:41];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_ok_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[45] == m_axis_tdata[0])
            && (m_axis_tdata[0] == (m_axis_tdata[43:41] == CAUSE_OK)))
        else $error("reading flag, health flag and cause disagree");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[40:1] == '0)
        else $error("value present without a reading");

    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[44] == (m_axis_tdata[43:41] != r_last_cause))
        else $error("cause change pulse wrong");

endmodule

bind sensor_sample_health_monitor sshm_check u_sshm_check (.*);
